[rtl/core/blp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blp_pkg
// Shared types and constants of the balanced label propagation move core.
// ---------------------------------------------------------------------------
package blp_pkg;

  localparam int unsigned VtxW   = 16;
  localparam int unsigned WgtW   = 16;
  localparam int unsigned PartW  = 6;
  localparam int unsigned TotW   = 32;
  localparam int unsigned CapW   = 40;
  localparam int unsigned CapFrac = 8;
  localparam int unsigned DivW   = CapW + CapFrac;
  localparam logic [TotW-1:0] Q16One = 32'h0001_0000;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_EDGE = 2'd1,
    FUNC_EVAL = 2'd2,
    FUNC_READ = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_REFINE = 2'd0,
    REG_PARTS  = 2'd1,
    REG_VCAP   = 2'd2,
    REG_ECAP   = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [VtxW-1:0]  vertex;
    logic [WgtW-1:0]  vertex_weight;
    logic [WgtW-1:0]  vertex_degree;
    logic [PartW-1:0] part_in;
    logic [VtxW-1:0]  neighbor;
    logic [WgtW-1:0]  edge_weight;
    logic             last_neighbor;
  } item_t;

  typedef struct packed {
    logic [VtxW-1:0]  vertex_out;
    logic [PartW-1:0] old_part;
    logic [PartW-1:0] new_part;
    logic             moved;
    logic [TotW-1:0]  largest_edge_total;
  } result_t;

  typedef struct packed {
    logic [1:0]      reg_index;
    logic [CapW-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic            refine_mode;
    logic [6:0]      parts_in_use;
    logic [CapW-1:0] vertex_capacity;
    logic [CapW-1:0] edge_capacity;
  } cfg_regs_t;

  typedef struct packed {
    func_e            op;
    logic             decide;
    logic [VtxW-1:0]  vertex;
    logic [WgtW-1:0]  vertex_weight;
    logic [WgtW-1:0]  vertex_degree;
    logic [PartW-1:0] part_in;
    logic [VtxW-1:0]  neighbor;
    logic [WgtW-1:0]  edge_weight;
  } ent_t;

endpackage

[rtl/core/blp_stream_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blp_stream_if
// Valid/ready channel carrying one payload of a given type.
// ---------------------------------------------------------------------------
interface blp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/blp_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module blp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/blp_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blp_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module blp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [blp_pkg::DivW-1:0]  dividend_i,
  input  logic [blp_pkg::TotW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [blp_pkg::DivW-1:0]  quot_o
);

  localparam int unsigned DW = blp_pkg::DivW;
  localparam int unsigned RW = blp_pkg::TotW;
  localparam int unsigned NW = $clog2(DW + 1);

  logic          busy_q;
  logic [NW-1:0] cnt_q;
  logic [DW-1:0] quot_q;
  logic [RW-1:0] rem_q;
  logic [RW-1:0] dsr_q;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, quot_q[DW-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = trial >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= NW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[RW-1:0] : trial[RW-1:0];
      quot_q <= {quot_q[DW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

[rtl/core/blp_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blp_front
// Accepts input items, decodes their function and queues them for the back.
// ---------------------------------------------------------------------------
module blp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  blp_stream_if.sink           items_i,
  output logic                 head_valid_o,
  output blp_pkg::ent_t        head_o,
  input  logic                 pop_i
);

  logic [1:0]    cnt_q, cnt_d;
  logic          wptr_q, rptr_q;
  blp_pkg::ent_t slot_q [2];
  blp_pkg::ent_t ent;
  logic          push;
  logic          pop;

  always_comb begin
    ent.op            = blp_pkg::func_e'(items_i.data.func);
    ent.decide        = (items_i.data.func == blp_pkg::FUNC_EVAL) ||
                        ((items_i.data.func == blp_pkg::FUNC_EDGE) &&
                         items_i.data.last_neighbor);
    ent.vertex        = items_i.data.vertex;
    ent.vertex_weight = items_i.data.vertex_weight;
    ent.vertex_degree = items_i.data.vertex_degree;
    ent.part_in       = items_i.data.part_in;
    ent.neighbor      = items_i.data.neighbor;
    ent.edge_weight   = items_i.data.edge_weight;
  end

  assign items_i.ready = (cnt_q != 2'd2);
  assign push          = items_i.valid && items_i.ready;
  assign pop           = pop_i && (cnt_q != 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= ent;
    end
  end

  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = slot_q[rptr_q];

endmodule

[rtl/core/blp_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blp_back
// Sequencer that keeps labels, totals and tallies and makes move decisions.
// ---------------------------------------------------------------------------
module blp_back #(
  parameter int unsigned MAX_PARTS    = 64,
  parameter int unsigned MAX_VERTICES = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  blp_pkg::cfg_regs_t   cfg_i,
  input  logic                 head_valid_i,
  input  blp_pkg::ent_t        head_i,
  output logic                 pop_o,
  blp_stream_if.source         results_o
);

  localparam int unsigned PW = $clog2(MAX_PARTS);
  localparam int unsigned CW = $clog2(MAX_PARTS + 1);
  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned LW = (PW > blp_pkg::PartW) ? PW : blp_pkg::PartW;
  localparam int unsigned TW = blp_pkg::TotW;
  localparam int unsigned SW = 3 * TW;

  typedef enum logic [22:0] {
    S_IDLE    = 23'd1 << 0,
    S_LD_WR   = 23'd1 << 1,
    S_NB_LBL  = 23'd1 << 2,
    S_NB_WR   = 23'd1 << 3,
    S_DC_LBL  = 23'd1 << 4,
    S_RF_RD   = 23'd1 << 5,
    S_RF_CMP  = 23'd1 << 6,
    S_RF_TOT  = 23'd1 << 7,
    S_RF_CHK  = 23'd1 << 8,
    S_BL_RD   = 23'd1 << 9,
    S_BL_DIV0 = 23'd1 << 10,
    S_BL_DIV  = 23'd1 << 11,
    S_BL_MUL1 = 23'd1 << 12,
    S_BL_MUL2 = 23'd1 << 13,
    S_BL_CMP  = 23'd1 << 14,
    S_UP0     = 23'd1 << 15,
    S_UP_SUB  = 23'd1 << 16,
    S_UP_ADD  = 23'd1 << 17,
    S_MX_RD   = 23'd1 << 18,
    S_MX_ACC  = 23'd1 << 19,
    S_OUT     = 23'd1 << 20,
    S_SPARE0  = 23'd1 << 21,
    S_SPARE1  = 23'd1 << 22
  } state_e;

  state_e                state_q, state_d;
  blp_pkg::ent_t         ent_q, ent_d;
  logic [CW-1:0]         p_q, p_d;
  logic [LW-1:0]         part_q, part_d;
  logic [LW-1:0]         best_q, best_d;
  logic [TW-1:0]         bt_q, bt_d;
  logic [SW-1:0]         bs_q, bs_d;
  logic [TW-1:0]         mx_q, mx_d;
  logic [TW-1:0]         t_q, t_d;
  logic [2*TW-1:0]       prod_q, prod_d;
  logic [2*TW-1:0]       lo_q, lo_d;
  logic [2*TW-1:0]       hi_q, hi_d;
  blp_pkg::result_t      res_q, res_d;
  logic                  res_v_q, res_v_d;
  logic [MAX_PARTS-1:0]  tv_q, tv_d;
  logic [MAX_PARTS-1:0]  tl_q, tl_d;
  logic [PW-1:0]         tot_ra_q, tal_ra_q;

  logic                  lbl_we;
  logic [VW-1:0]         lbl_wa, lbl_ra;
  logic [LW-1:0]         lbl_wd, lbl_rd;
  logic                  tot_we;
  logic [PW-1:0]         tot_wa, tot_ra;
  logic [TW-1:0]         vt_wd, et_wd, vt_raw, et_raw, vt_rd, et_rd;
  logic                  tal_we;
  logic [PW-1:0]         tal_wa, tal_ra;
  logic [TW-1:0]         tal_wd, tal_raw, tal_rd;

  logic                  div_start, busy_v, busy_e;
  logic [blp_pkg::DivW-1:0] quot_v, quot_e;
  logic [TW-1:0]         fv, fe;
  logic [CW-1:0]         k;
  logic                  last_p;
  logic [TW:0]           tsum, ns, ne;
  logic [SW-1:0]         score;
  logic                  fit;

  function automatic logic in_rng(input logic [LW-1:0] lbl);
    return 32'(lbl) < 32'(MAX_PARTS);
  endfunction

  function automatic logic [TW-1:0] factor(input logic [blp_pkg::DivW-1:0] q);
    logic [TW-1:0] s;
    s = (|q[blp_pkg::DivW-1:TW]) ? '1 : q[TW-1:0];
    return (s > blp_pkg::Q16One) ? s - blp_pkg::Q16One : '0;
  endfunction

  blp_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_label (
    .clk_i, .we_i(lbl_we), .waddr_i(lbl_wa), .wdata_i(lbl_wd),
    .raddr_i(lbl_ra), .rdata_o(lbl_rd)
  );
  blp_ram #(.WIDTH(TW), .DEPTH(MAX_PARTS)) u_vtot (
    .clk_i, .we_i(tot_we), .waddr_i(tot_wa), .wdata_i(vt_wd),
    .raddr_i(tot_ra), .rdata_o(vt_raw)
  );
  blp_ram #(.WIDTH(TW), .DEPTH(MAX_PARTS)) u_etot (
    .clk_i, .we_i(tot_we), .waddr_i(tot_wa), .wdata_i(et_wd),
    .raddr_i(tot_ra), .rdata_o(et_raw)
  );
  blp_ram #(.WIDTH(TW), .DEPTH(MAX_PARTS)) u_tally (
    .clk_i, .we_i(tal_we), .waddr_i(tal_wa), .wdata_i(tal_wd),
    .raddr_i(tal_ra), .rdata_o(tal_raw)
  );

  blp_div u_div_v (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i({cfg_i.vertex_capacity, {blp_pkg::CapFrac{1'b0}}}),
    .divisor_i(vt_rd), .busy_o(busy_v), .quot_o(quot_v)
  );
  blp_div u_div_e (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i({cfg_i.edge_capacity, {blp_pkg::CapFrac{1'b0}}}),
    .divisor_i(et_rd), .busy_o(busy_e), .quot_o(quot_e)
  );

  // entries never written read as zero
  assign vt_rd  = tv_q[tot_ra_q] ? vt_raw : '0;
  assign et_rd  = tv_q[tot_ra_q] ? et_raw : '0;
  assign tal_rd = tl_q[tal_ra_q] ? tal_raw : '0;

  always_comb begin
    if (cfg_i.parts_in_use == 7'd0) begin
      k = CW'(1);
    end else if (32'(cfg_i.parts_in_use) > 32'(MAX_PARTS)) begin
      k = CW'(MAX_PARTS);
    end else begin
      k = CW'(cfg_i.parts_in_use);
    end
  end

  assign last_p = (p_q + CW'(1)) == k;
  assign fv     = factor(quot_v);
  assign fe     = factor(quot_e);
  assign score  = {{TW{1'b0}}, lo_q} + {hi_q, {TW{1'b0}}};
  assign tsum   = {1'b0, tal_rd} + (TW + 1)'(ent_q.edge_weight);
  assign ns     = {1'b0, vt_rd} + (TW + 1)'(ent_q.vertex_weight);
  assign ne     = {1'b0, et_rd} + (TW + 1)'(ent_q.vertex_degree);
  assign fit    = ({ns, {blp_pkg::CapFrac{1'b0}}} < {1'b0, cfg_i.vertex_capacity}) &&
                  ({ne, {blp_pkg::CapFrac{1'b0}}} < {1'b0, cfg_i.edge_capacity});

  always_comb begin
    state_d = state_q;
    ent_d   = ent_q;
    p_d     = p_q;
    part_d  = part_q;
    best_d  = best_q;
    bt_d    = bt_q;
    bs_d    = bs_q;
    mx_d    = mx_q;
    t_d     = t_q;
    prod_d  = prod_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    res_d   = res_q;
    res_v_d = res_v_q && !results_o.ready;
    tv_d    = tv_q;
    tl_d    = tl_q;
    pop_o   = 1'b0;
    lbl_we  = 1'b0;
    lbl_wa  = VW'(ent_q.vertex);
    lbl_wd  = best_q;
    lbl_ra  = VW'(head_i.vertex);
    tot_we  = 1'b0;
    tot_wa  = tot_ra_q;
    tot_ra  = tot_ra_q;
    vt_wd   = vt_rd + TW'(ent_q.vertex_weight);
    et_wd   = et_rd + TW'(ent_q.vertex_degree);
    tal_we  = 1'b0;
    tal_wa  = tal_ra_q;
    tal_wd  = tsum[TW] ? '1 : tsum[TW-1:0];
    tal_ra  = tal_ra_q;
    div_start = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          ent_d = head_i;
          case (head_i.op)
            blp_pkg::FUNC_LOAD: begin
              lbl_we = 1'b1;
              lbl_wa = VW'(head_i.vertex);
              lbl_wd = LW'(head_i.part_in);
              if (in_rng(LW'(head_i.part_in))) begin
                tot_ra  = PW'(head_i.part_in);
                state_d = S_LD_WR;
              end
            end
            blp_pkg::FUNC_EDGE: begin
              lbl_ra  = VW'(head_i.neighbor);
              state_d = S_NB_LBL;
            end
            default: begin
              state_d = S_DC_LBL;
            end
          endcase
        end
      end
      S_LD_WR: begin
        tot_we = 1'b1;
        tv_d[tot_ra_q] = 1'b1;
        state_d = S_IDLE;
      end
      S_NB_LBL: begin
        lbl_ra = VW'(ent_q.vertex);
        if (in_rng(lbl_rd)) begin
          tal_ra  = PW'(lbl_rd);
          state_d = S_NB_WR;
        end else if (ent_q.decide) begin
          state_d = S_DC_LBL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_NB_WR: begin
        tal_we = 1'b1;
        tl_d[tal_ra_q] = 1'b1;
        lbl_ra  = VW'(ent_q.vertex);
        state_d = ent_q.decide ? S_DC_LBL : S_IDLE;
      end
      S_DC_LBL: begin
        part_d = lbl_rd;
        p_d    = '0;
        mx_d   = '0;
        bs_d   = '0;
        best_d = lbl_rd;
        if (ent_q.op == blp_pkg::FUNC_READ) begin
          state_d = S_MX_RD;
        end else if (cfg_i.refine_mode) begin
          state_d = S_RF_RD;
        end else begin
          state_d = S_BL_RD;
        end
      end
      S_RF_RD: begin
        tal_ra  = PW'(p_q);
        state_d = S_RF_CMP;
      end
      S_RF_CMP: begin
        if ((p_q == '0) || (tal_rd > bt_q)) begin
          bt_d   = tal_rd;
          best_d = LW'(p_q);
        end
        if (last_p) begin
          state_d = S_RF_TOT;
        end else begin
          p_d     = p_q + CW'(1);
          state_d = S_RF_RD;
        end
      end
      S_RF_TOT: begin
        tot_ra  = PW'(best_q);
        state_d = S_RF_CHK;
      end
      S_RF_CHK: begin
        if ((best_q != part_q) && !fit) begin
          best_d = part_q;
        end
        state_d = S_UP0;
      end
      S_BL_RD: begin
        tot_ra  = PW'(p_q);
        tal_ra  = PW'(p_q);
        state_d = S_BL_DIV0;
      end
      S_BL_DIV0: begin
        t_d       = tal_rd;
        div_start = 1'b1;
        state_d   = S_BL_DIV;
      end
      S_BL_DIV: begin
        if (!busy_v && !busy_e) begin
          state_d = S_BL_MUL1;
        end
      end
      S_BL_MUL1: begin
        prod_d  = (2*TW)'(fv) * (2*TW)'(fe);
        state_d = S_BL_MUL2;
      end
      S_BL_MUL2: begin
        lo_d    = (2*TW)'(prod_q[TW-1:0]) * (2*TW)'(t_q);
        hi_d    = (2*TW)'(prod_q[2*TW-1:TW]) * (2*TW)'(t_q);
        state_d = S_BL_CMP;
      end
      S_BL_CMP: begin
        if (score > bs_q) begin
          bs_d   = score;
          best_d = LW'(p_q);
        end
        if (last_p) begin
          state_d = S_UP0;
        end else begin
          p_d     = p_q + CW'(1);
          state_d = S_BL_RD;
        end
      end
      S_UP0: begin
        tl_d = '0;
        p_d  = '0;
        mx_d = '0;
        if (best_q == part_q) begin
          state_d = S_MX_RD;
        end else begin
          lbl_we = 1'b1;
          if (in_rng(part_q)) begin
            tot_ra  = PW'(part_q);
            state_d = S_UP_SUB;
          end else begin
            tot_ra  = PW'(best_q);
            state_d = S_UP_ADD;
          end
        end
      end
      S_UP_SUB: begin
        tot_we = 1'b1;
        vt_wd  = vt_rd - TW'(ent_q.vertex_weight);
        et_wd  = et_rd - TW'(ent_q.vertex_degree);
        tv_d[tot_ra_q] = 1'b1;
        tot_ra  = PW'(best_q);
        state_d = S_UP_ADD;
      end
      S_UP_ADD: begin
        tot_we = 1'b1;
        tv_d[tot_ra_q] = 1'b1;
        state_d = S_MX_RD;
      end
      S_MX_RD: begin
        tot_ra  = PW'(p_q);
        state_d = S_MX_ACC;
      end
      S_MX_ACC: begin
        if (et_rd > mx_q) begin
          mx_d = et_rd;
        end
        if (last_p) begin
          state_d = S_OUT;
        end else begin
          p_d     = p_q + CW'(1);
          state_d = S_MX_RD;
        end
      end
      S_OUT: begin
        if (!res_v_q || results_o.ready) begin
          res_d.vertex_out         = ent_q.vertex;
          res_d.old_part           = part_q[blp_pkg::PartW-1:0];
          res_d.largest_edge_total = mx_q;
          if (ent_q.op == blp_pkg::FUNC_READ) begin
            res_d.new_part = part_q[blp_pkg::PartW-1:0];
            res_d.moved    = 1'b0;
          end else begin
            res_d.new_part = best_q[blp_pkg::PartW-1:0];
            res_d.moved    = best_q != part_q;
          end
          res_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_v_q <= 1'b0;
      tv_q    <= '0;
      tl_q    <= '0;
    end else begin
      state_q <= state_d;
      res_v_q <= res_v_d;
      tv_q    <= tv_d;
      tl_q    <= tl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q    <= ent_d;
    p_q      <= p_d;
    part_q   <= part_d;
    best_q   <= best_d;
    bt_q     <= bt_d;
    bs_q     <= bs_d;
    mx_q     <= mx_d;
    t_q      <= t_d;
    prod_q   <= prod_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    res_q    <= res_d;
    tot_ra_q <= tot_ra;
    tal_ra_q <= tal_ra;
  end

  assign results_o.valid = res_v_q;
  assign results_o.data  = res_q;

endmodule

[rtl/core/balanced_label_propagation_move_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// balanced_label_propagation_move_core
// Move decision unit for balanced label propagation graph partitioning.
// ---------------------------------------------------------------------------
// Items enter a two-entry queue and are worked one at a time by a sequencer
// that holds the vertex labels in a RAM and per-part totals and tallies in
// small RAMs. In balance mode two bit-serial dividers work out each part's
// capacity factors. The output register lets the next item start while a
// result waits to be taken.
// Configuration writes are taken at once and must come only while idle.
module balanced_label_propagation_move_core #(
  parameter int unsigned MAX_PARTS    = 64,
  parameter int unsigned MAX_VERTICES = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  blp_stream_if.sink   cfg_i,
  blp_stream_if.sink   items_i,
  blp_stream_if.source results_o
);

  blp_pkg::cfg_regs_t cfg_q;
  logic               head_valid;
  blp_pkg::ent_t      head;
  logic               pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.refine_mode     <= 1'b0;
      cfg_q.parts_in_use    <= 7'd2;
      cfg_q.vertex_capacity <= '0;
      cfg_q.edge_capacity   <= '0;
    end else if (cfg_i.valid) begin
      case (blp_pkg::reg_e'(cfg_i.data.reg_index))
        blp_pkg::REG_REFINE: cfg_q.refine_mode     <= cfg_i.data.wdata[0];
        blp_pkg::REG_PARTS:  cfg_q.parts_in_use    <= cfg_i.data.wdata[6:0];
        blp_pkg::REG_VCAP:   cfg_q.vertex_capacity <= cfg_i.data.wdata;
        blp_pkg::REG_ECAP:   cfg_q.edge_capacity   <= cfg_i.data.wdata;
        default: begin
        end
      endcase
    end
  end

  blp_front u_front (
    .clk_i, .rst_ni, .items_i,
    .head_valid_o(head_valid), .head_o(head), .pop_i(pop)
  );

  blp_back #(.MAX_PARTS(MAX_PARTS), .MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .head_valid_i(head_valid), .head_i(head), .pop_o(pop), .results_o
  );

endmodule

[rtl/core/blp_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blp_checker
// Port-level checks of the move core, attached to the top level by bind.
// ---------------------------------------------------------------------------
module blp_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input blp_pkg::result_t res_i,
  input logic             cfg_ready_i
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_i))
    else $error("result dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !res_valid_i)
    else $error("result shown right after reset");

  a_stay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_i.moved |-> res_i.old_part == res_i.new_part)
    else $error("unmoved vertex changed part");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port stalled");

endmodule

bind balanced_label_propagation_move_core blp_checker u_blp_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .res_valid_i(results_o.valid),
  .res_ready_i(results_o.ready),
  .res_i(results_o.data),
  .cfg_ready_i(cfg_i.ready)
);

[tb/balanced_label_propagation_move_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// balanced_label_propagation_move_core_tb
// Self-checking bench for the balanced label propagation move core.
// ---------------------------------------------------------------------------
// Loads, neighbor edges, isolated evaluates and label reads are queued
// together with the move decisions and label reads a bit-accurate predictor
// works out for them. The monitor checks each result transfer against the
// oldest prediction. The run steps through several register settings in both
// scoring modes, with random idling on both sides and a long result stall.
// ---------------------------------------------------------------------------
module balanced_label_propagation_move_core_tb;

  localparam int unsigned NumParts = 64;
  localparam int unsigned CycleLimit = 20000000;
  localparam int unsigned DrainWait = 300;
  localparam int unsigned ItemW = $bits(blp_pkg::item_t);
  localparam logic [blp_pkg::CapW-1:0] CapMax = {blp_pkg::CapW{1'b1}};

  logic clk_i;
  logic rst_ni;

  blp_stream_if #(.T(blp_pkg::cfg_wr_t)) cfg_if ();
  blp_stream_if #(.T(blp_pkg::item_t))   items_if ();
  blp_stream_if #(.T(blp_pkg::result_t)) res_if ();

  balanced_label_propagation_move_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_if),
    .items_i   (items_if),
    .results_o (res_if)
  );

  // predictor state
  logic [blp_pkg::PartW-1:0] label_mem [65536];
  bit                        label_known [65536];
  int unsigned               loaded_vtx [$];
  logic [blp_pkg::TotW-1:0]  vtx_total [NumParts];
  logic [blp_pkg::TotW-1:0]  edge_total [NumParts];
  logic [blp_pkg::TotW-1:0]  tally [NumParts];
  logic                      cur_refine;
  logic [6:0]                cur_parts;
  logic [blp_pkg::CapW-1:0]  cur_vcap;
  logic [blp_pkg::CapW-1:0]  cur_ecap;

  blp_pkg::item_t   pend_q [$];
  blp_pkg::result_t exp_q [$];
  int unsigned      errors;
  int unsigned      cycles;
  bit               idle_on;
  bit               item_taken;
  bit               hold_req;
  bit               hold_done;
  int unsigned      hold_left;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int unsigned active_parts();
    if (cur_parts < 1) return 1;
    if (cur_parts > NumParts) return NumParts;
    return cur_parts;
  endfunction

  function automatic logic [blp_pkg::TotW-1:0] largest_edge();
    logic [blp_pkg::TotW-1:0] m;
    m = '0;
    for (int p = 0; p < active_parts(); p++) begin
      if (edge_total[p] > m) m = edge_total[p];
    end
    return m;
  endfunction

  function automatic logic [31:0] cap_factor(logic [blp_pkg::CapW-1:0] cap,
                                             logic [blp_pkg::TotW-1:0] tot);
    logic [47:0] q;
    if (tot == 0) begin
      q = 48'hFFFF_FFFF;
    end else begin
      q = {cap, 8'h00} / {16'h0, tot};
      if (q > 48'hFFFF_FFFF) q = 48'hFFFF_FFFF;
    end
    return (q > 48'h1_0000) ? 32'(q - 48'h1_0000) : 32'h0;
  endfunction

  task automatic decide_move(blp_pkg::item_t it);
    int unsigned cur, best, k;
    logic [63:0] ns, ne, f;
    logic [95:0] sc, best_sc;
    blp_pkg::result_t r;
    k = active_parts();
    cur = label_mem[it.vertex];
    if (cur_refine) begin
      best = 0;
      for (int p = 1; p < k; p++) begin
        if (tally[p] > tally[best]) best = p;
      end
      if (best != cur) begin
        ns = {32'h0, vtx_total[best]} + it.vertex_weight;
        ne = {32'h0, edge_total[best]} + it.vertex_degree;
        if (!((ns << 8) < cur_vcap && (ne << 8) < cur_ecap)) best = cur;
      end
    end else begin
      best = cur;
      best_sc = '0;
      for (int p = 0; p < k; p++) begin
        f = 64'(cap_factor(cur_vcap, vtx_total[p])) *
            64'(cap_factor(cur_ecap, edge_total[p]));
        sc = 96'(tally[p]) * 96'(f);
        if (sc > best_sc) begin
          best_sc = sc;
          best = p;
        end
      end
    end
    if (best != cur) begin
      label_mem[it.vertex] = blp_pkg::PartW'(best);
      vtx_total[cur] -= 32'(it.vertex_weight);
      edge_total[cur] -= 32'(it.vertex_degree);
      vtx_total[best] += 32'(it.vertex_weight);
      edge_total[best] += 32'(it.vertex_degree);
    end
    for (int p = 0; p < NumParts; p++) tally[p] = '0;
    r.vertex_out = it.vertex;
    r.old_part = blp_pkg::PartW'(cur);
    r.new_part = blp_pkg::PartW'(best);
    r.moved = (best != cur);
    r.largest_edge_total = largest_edge();
    exp_q.push_back(r);
  endtask

  task automatic queue_item(blp_pkg::item_t it);
    logic [32:0] t;
    blp_pkg::result_t r;
    pend_q.push_back(it);
    case (blp_pkg::func_e'(it.func))
      blp_pkg::FUNC_LOAD: begin
        label_mem[it.vertex] = it.part_in;
        if (!label_known[it.vertex]) begin
          label_known[it.vertex] = 1'b1;
          loaded_vtx.push_back(it.vertex);
        end
        vtx_total[it.part_in] += 32'(it.vertex_weight);
        edge_total[it.part_in] += 32'(it.vertex_degree);
      end
      blp_pkg::FUNC_EDGE: begin
        t = {1'b0, tally[label_mem[it.neighbor]]} + it.edge_weight;
        tally[label_mem[it.neighbor]] = t[32] ? 32'hFFFF_FFFF : t[31:0];
        if (it.last_neighbor) decide_move(it);
      end
      blp_pkg::FUNC_EVAL: decide_move(it);
      default: begin
        r.vertex_out = it.vertex;
        r.old_part = label_mem[it.vertex];
        r.new_part = label_mem[it.vertex];
        r.moved = 1'b0;
        r.largest_edge_total = largest_edge();
        exp_q.push_back(r);
      end
    endcase
  endtask

  function automatic blp_pkg::item_t rand_item(blp_pkg::func_e fn);
    blp_pkg::item_t it;
    it = blp_pkg::item_t'(ItemW'({$urandom, $urandom, $urandom}));
    it.func = fn;
    if ($urandom_range(1)) it.vertex_weight = 16'($urandom_range(1, 64));
    if (it.vertex_weight == 0) it.vertex_weight = 16'd1;
    if (it.edge_weight == 0) it.edge_weight = 16'd1;
    if (fn != blp_pkg::FUNC_LOAD) begin
      it.vertex = 16'(loaded_vtx[$urandom_range(loaded_vtx.size() - 1)]);
      it.neighbor = 16'(loaded_vtx[$urandom_range(loaded_vtx.size() - 1)]);
    end else if ($urandom_range(9) < 7) begin
      it.part_in = blp_pkg::PartW'($urandom_range(active_parts() - 1));
    end
    return it;
  endfunction

  function automatic blp_pkg::item_t mk_item(blp_pkg::func_e fn, logic [15:0] v,
                                             logic [15:0] w, logic [15:0] d,
                                             logic [5:0] p, logic [15:0] nb,
                                             logic [15:0] ew, logic last);
    blp_pkg::item_t it;
    it.func = fn;
    it.vertex = v;
    it.vertex_weight = w;
    it.vertex_degree = d;
    it.part_in = p;
    it.neighbor = nb;
    it.edge_weight = ew;
    it.last_neighbor = last;
    return it;
  endfunction

  task automatic cfg_write(blp_pkg::reg_e idx, logic [blp_pkg::CapW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data = '{reg_index: idx, wdata: val};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    case (idx)
      blp_pkg::REG_REFINE: cur_refine = val[0];
      blp_pkg::REG_PARTS:  cur_parts = val[6:0];
      blp_pkg::REG_VCAP:   cur_vcap = val;
      default:             cur_ecap = val;
    endcase
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || items_if.valid || exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic [blp_pkg::CapW-1:0] rand_cap();
    case ($urandom_range(3))
      0: return blp_pkg::CapW'({$urandom, $urandom});
      1: return blp_pkg::CapW'($urandom_range(1 << 24, 1 << 31));
      2: return blp_pkg::CapW'($urandom_range(1 << 20, 1 << 27));
      default: return CapMax;
    endcase
  endfunction

  task automatic run_phase(logic refine, logic [6:0] parts,
                           logic [blp_pkg::CapW-1:0] vcap,
                           logic [blp_pkg::CapW-1:0] ecap, int unsigned n);
    int unsigned cnt, len, r;
    bit broken;
    blp_pkg::item_t it;
    cfg_write(blp_pkg::REG_REFINE, blp_pkg::CapW'(refine));
    cfg_write(blp_pkg::REG_PARTS, blp_pkg::CapW'(parts));
    cfg_write(blp_pkg::REG_VCAP, vcap);
    cfg_write(blp_pkg::REG_ECAP, ecap);
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (loaded_vtx.size() < 4 || r < 28) begin
        queue_item(rand_item(blp_pkg::FUNC_LOAD));
        cnt++;
      end else if (r < 78) begin
        len = $urandom_range(1, 6);
        broken = ($urandom_range(9) == 0);
        for (int i = 0; i < len; i++) begin
          it = rand_item(blp_pkg::FUNC_EDGE);
          it.last_neighbor = (i == len - 1) && !broken;
          queue_item(it);
        end
        cnt += len;
      end else if (r < 88) begin
        queue_item(rand_item(blp_pkg::FUNC_READ));
        cnt++;
      end else begin
        queue_item(rand_item(blp_pkg::FUNC_EVAL));
        cnt++;
      end
    end
    wait_drained();
  endtask

  // item driver
  always @(posedge clk_i) item_taken <= items_if.valid && items_if.ready;

  always @(negedge clk_i) begin : item_drv
    logic           nv;
    blp_pkg::item_t nd;
    if (rst_ni) begin
      nv = items_if.valid;
      nd = items_if.data;
      if (nv && item_taken) nv = 1'b0;
      if (!nv && pend_q.size() != 0 && !(idle_on && $urandom_range(99) < 36)) begin
        nd = pend_q.pop_front();
        nv = 1'b1;
      end
      items_if.valid <= nv;
      items_if.data <= nd;
    end else begin
      items_if.valid <= 1'b0;
      items_if.data <= '0;
    end
  end

  // result ready with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left <= 600;
      hold_done <= 1'b1;
      res_if.ready <= 1'b0;
    end else begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      res_if.ready <= rst_ni && hold_left <= 1 && !(idle_on && $urandom_range(99) < 36);
    end
  end

  // result monitor
  always @(posedge clk_i) begin : res_mon
    blp_pkg::result_t e, a;
    if (res_if.valid && res_if.ready) begin
      a = res_if.data;
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %p", $time, a);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (a.vertex_out !== e.vertex_out) begin
          $display("%0t: vertex_out expected %0d actual %0d", $time, e.vertex_out, a.vertex_out);
          errors++;
        end
        if (a.old_part !== e.old_part) begin
          $display("%0t: old_part expected %0d actual %0d", $time, e.old_part, a.old_part);
          errors++;
        end
        if (a.new_part !== e.new_part) begin
          $display("%0t: new_part expected %0d actual %0d", $time, e.new_part, a.new_part);
          errors++;
        end
        if (a.moved !== e.moved) begin
          $display("%0t: moved expected %0d actual %0d", $time, e.moved, a.moved);
          errors++;
        end
        if (a.largest_edge_total !== e.largest_edge_total) begin
          $display("%0t: largest_edge_total expected %0d actual %0d", $time,
                   e.largest_edge_total, a.largest_edge_total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    idle_on = 1'b1;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    for (int p = 0; p < NumParts; p++) begin
      vtx_total[p] = '0;
      edge_total[p] = '0;
      tally[p] = '0;
    end
    cur_refine = 1'b0;
    cur_parts = 7'd2;
    cur_vcap = '0;
    cur_ecap = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed items under the reset settings
    queue_item(mk_item(blp_pkg::FUNC_LOAD, 16'h0000, 16'd1, 16'd0, 6'd0, 16'h0, 16'd1,
                       1'b0));
    queue_item(mk_item(blp_pkg::FUNC_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 16'hFFFF,
                       16'hFFFF, 1'b1));
    queue_item(mk_item(blp_pkg::FUNC_LOAD, 16'h5555, 16'h8000, 16'd1, 6'd1, 16'hAAAA,
                       16'd7, 1'b1));
    queue_item(mk_item(blp_pkg::FUNC_LOAD, 16'hAAAA, 16'd3, 16'd5, 6'd0, 16'h5555, 16'd9,
                       1'b0));
    queue_item(mk_item(blp_pkg::FUNC_READ, 16'h0000, 16'd1, 16'd0, 6'd0, 16'h0, 16'd1,
                       1'b0));
    queue_item(mk_item(blp_pkg::FUNC_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 16'hFFFF,
                       16'hFFFF, 1'b1));
    queue_item(mk_item(blp_pkg::FUNC_EDGE, 16'h0000, 16'd1, 16'd0, 6'd0, 16'hFFFF,
                       16'hFFFF, 1'b0));
    queue_item(mk_item(blp_pkg::FUNC_EDGE, 16'h0000, 16'd1, 16'd0, 6'd0, 16'h5555, 16'd1,
                       1'b1));
    queue_item(mk_item(blp_pkg::FUNC_EVAL, 16'hAAAA, 16'd3, 16'd5, 6'd0, 16'h0, 16'd1,
                       1'b0));
    queue_item(mk_item(blp_pkg::FUNC_LOAD, 16'h5555, 16'h8000, 16'd1, 6'd1, 16'h0, 16'd1,
                       1'b0));
    queue_item(mk_item(blp_pkg::FUNC_READ, 16'h5555, 16'd1, 16'd0, 6'd0, 16'h0, 16'd1,
                       1'b0));
    queue_item(mk_item(blp_pkg::FUNC_EDGE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0, 16'h0,
                       16'hFFFF, 1'b1));
    wait_drained();

    run_phase(1'b0, 7'd2, CapMax, CapMax, 110);
    queue_item(mk_item(blp_pkg::FUNC_EVAL, 16'hAAAA, 16'd3, 16'd5, 6'd0, 16'h0, 16'd1,
                       1'b0));
    wait_drained();
    run_phase(1'b1, 7'd64, CapMax, CapMax, 110);
    idle_on = 1'b0;
    run_phase(1'b0, 7'd8, rand_cap(), rand_cap(), 110);
    idle_on = 1'b1;
    hold_req = 1'b1;
    run_phase(1'b1, 7'd5, rand_cap(), rand_cap(), 110);
    run_phase(1'b0, 7'd64, '0, '0, 40);
    run_phase(1'b0, 7'd64, rand_cap(), rand_cap(), 30);
    run_phase(1'b1, 7'd3, rand_cap(), rand_cap(), 100);
    run_phase(1'b0, 7'd3, rand_cap(), rand_cap(), 100);

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/blp_pkg.sv
rtl/core/blp_stream_if.sv
rtl/core/blp_ram.sv
rtl/core/blp_div.sv
rtl/core/blp_front.sv
rtl/core/blp_back.sv
rtl/core/balanced_label_propagation_move_core.sv
rtl/core/blp_checker.sv
tb/balanced_label_propagation_move_core_tb.sv
